FILE: rtl/mqsb_pkg.sv
// Shared types and constants for the multi-queue shared buffer.
package mqsb_pkg;

   // Default geometry of the block
   localparam int DEF_ENTRIES    = 16;
   localparam int DEF_QUEUES     = 4;
   localparam int DEF_DATA_WIDTH = 32;

   // Fixed field widths
   localparam int OPCODE_W = 1;
   localparam int QIDX_W   = 2;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;

   // Operation codes
   localparam logic [OPCODE_W-1:0] OP_PUSH = 1'b0;
   localparam logic [OPCODE_W-1:0] OP_POP  = 1'b1;

   // Result status codes
   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

   typedef enum logic [1:0] {
      S_IDLE,
      S_LOOKUP,
      S_COMMIT
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic load;       // latch the item, launch pointer reads
      logic issue_pop;  // launch link and value reads at the queue head
      logic do_push;    // commit a push and post its result
      logic do_pop;     // commit a pop and post its result
      logic do_error;   // post an overflow or underflow result
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic is_pop;
      logic buf_full;
      logic q_empty;
      logic rsp_busy;
   } stat_type;

endpackage

FILE: rtl/multi_queue_shared_buffer.sv
// Top level of the multi-queue shared buffer: controller plus datapath.
//
// QUEUES FIFO queues share one pool of ENTRIES linked entries; unused
// entries sit on a free list. Each request item is a push (opcode 0, store
// value_in at the tail of queue queue_index) or a pop (opcode 1, return the
// head value of that queue); queue_index is taken modulo QUEUES. Every item
// yields exactly one response item: status 0 ok, 1 overflow (no free entry
// on push), 2 underflow (queue empty on pop); value_out is the popped value
// and zero otherwise, and an error leaves all state untouched. A push or an
// error passes through the accept cycle and a lookup cycle that posts
// the response into the output register. A pop passes through the
// accept, lookup and commit cycles and posts its response from the
// commit cycle: the head pointer read must return before the link and
// value memories can be read at that head, and each memory has a
// registered read port. One item is in flight at a time; a
// new request is taken in the cycle after the previous one has posted its
// response into the output register, even if that response still waits for
// rsp_ready. The next item then holds in its lookup or commit cycle until
// the output register is free, so a stalled receiver adds its stall to
// that item. No clearing pass runs after reset: a fill count marks entries
// that were never handed out, so the block accepts items from the first
// cycle after reset.
module multi_queue_shared_buffer #(
   parameter int ENTRIES    = mqsb_pkg::DEF_ENTRIES,
   parameter int QUEUES     = mqsb_pkg::DEF_QUEUES,
   parameter int DATA_WIDTH = mqsb_pkg::DEF_DATA_WIDTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [mqsb_pkg::OPCODE_W-1:0]       req_opcode,
   input  logic [mqsb_pkg::QIDX_W-1:0]         req_queue_index,
   input  logic signed [mqsb_pkg::VALUE_W-1:0] req_value_in,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [mqsb_pkg::VALUE_W-1:0] rsp_value_out,
   output logic [mqsb_pkg::STATUS_W-1:0]       rsp_status
);
   import mqsb_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // Sequence each item: lookup, optional pop commit, post the response
   mqsb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Hold pointers, links, values and the response register
   mqsb_dpath #(
      .ENTRIES    (ENTRIES),
      .QUEUES     (QUEUES),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_opcode      (req_opcode),
      .req_queue_index (req_queue_index),
      .req_value_in    (req_value_in),
      .rsp_ready       (rsp_ready),
      .rsp_valid       (rsp_valid),
      .rsp_value_out   (rsp_value_out),
      .rsp_status      (rsp_status)
   );

   // One item in flight: no second accept right after an accept
   a_single_flight : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while an item is in flight");

   // A fresh response never appears in the cycle right after acceptance
   a_min_latency : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_valid && req_ready))
      else $error("response posted too early");

   // Error responses carry a zero value
   a_error_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != ST_OK)) |-> (rsp_value_out == '0))
      else $error("error response with nonzero value");

endmodule

FILE: rtl/mqsb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mqsb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/mqsb_ctrl.sv
// Sequencing state machine for the multi-queue shared buffer.
module mqsb_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               rsp_ready,
   input  mqsb_pkg::stat_type stat,
   output mqsb_pkg::cmd_type  cmd
);
   import mqsb_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      out_free;

   assign out_free = !stat.rsp_busy || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_LOOKUP;
            end
         end
         S_LOOKUP: begin
            if (stat.is_pop && !stat.q_empty) begin
               state_in = S_COMMIT;
            end else if (out_free) begin
               state_in = S_IDLE;
            end
         end
         S_COMMIT: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready     = 1'b0;
      cmd           = '0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         S_LOOKUP: begin
            if (stat.is_pop) begin
               if (!stat.q_empty) begin
                  cmd.issue_pop = 1'b1;
               end else begin
                  cmd.do_error = out_free;
               end
            end else if (stat.buf_full) begin
               cmd.do_error = out_free;
            end else begin
               cmd.do_push = out_free;
            end
         end
         S_COMMIT: begin
            cmd.do_pop = out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

FILE: rtl/mqsb_dpath.sv
// Pointer, link and value storage with the result register.
module mqsb_dpath #(
   parameter int ENTRIES    = mqsb_pkg::DEF_ENTRIES,
   parameter int QUEUES     = mqsb_pkg::DEF_QUEUES,
   parameter int DATA_WIDTH = mqsb_pkg::DEF_DATA_WIDTH
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  mqsb_pkg::cmd_type                     cmd,
   output mqsb_pkg::stat_type                    stat,
   input  logic [mqsb_pkg::OPCODE_W-1:0]         req_opcode,
   input  logic [mqsb_pkg::QIDX_W-1:0]           req_queue_index,
   input  logic signed [mqsb_pkg::VALUE_W-1:0]   req_value_in,
   input  logic                                  rsp_ready,
   output logic                                  rsp_valid,
   output logic signed [mqsb_pkg::VALUE_W-1:0]   rsp_value_out,
   output logic [mqsb_pkg::STATUS_W-1:0]         rsp_status
);
   import mqsb_pkg::*;

   localparam int PTR_W = $clog2(ENTRIES + 1);
   localparam int AW    = $clog2(ENTRIES);
   localparam int QW    = (QUEUES > 1) ? $clog2(QUEUES) : 1;
   localparam logic [PTR_W-1:0] NIL = PTR_W'(ENTRIES);

   // Item registers
   logic [OPCODE_W-1:0]   op_ff;
   logic [QW-1:0]         q_ff;
   logic [DATA_WIDTH-1:0] val_ff;

   // Free list head, count of entries ever handed out, queue occupancy
   logic [PTR_W-1:0]  free_head_ff, free_head_in;
   logic [PTR_W-1:0]  fill_ff, fill_in;
   logic [QUEUES-1:0] qvalid_ff, qvalid_in;

   // Result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]  rsp_value_ff, rsp_value_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   logic [QW-1:0]         q_req;
   logic [PTR_W-1:0]      head_rd, tail_rd, link_rd;
   logic [DATA_WIDTH-1:0] value_rd;
   logic [PTR_W-1:0]      next_free;
   logic                  fresh;
   logic                  link_we;
   logic [AW-1:0]         link_wa;
   logic [AW-1:0]         link_ra;
   logic [PTR_W-1:0]      head_wd;
   logic [DATA_WIDTH+VALUE_W-1:0] wr_ext;
   logic [DATA_WIDTH+VALUE_W-1:0] rd_ext;

   // Fold an out-of-range queue number back into range; the index field is
   // narrow enough that one subtraction does it whenever QUEUES > 1.
   assign q_req = (QUEUES == 1) ? QW'(0) :
                  (int'(req_queue_index) >= QUEUES) ?
                     QW'(int'(req_queue_index) - QUEUES) :
                     QW'(req_queue_index);

   assign wr_ext = {{DATA_WIDTH{1'b0}}, req_value_in};
   assign rd_ext = {{VALUE_W{1'b0}}, value_rd};

   // An entry at or past the fill count was never handed out; it still
   // links to its successor.
   assign fresh     = (free_head_ff == fill_ff);
   assign next_free = fresh ? (free_head_ff + PTR_W'(1)) : link_rd;

   assign stat.is_pop   = (op_ff == OP_POP);
   assign stat.buf_full = (free_head_ff == NIL);
   assign stat.q_empty  = !qvalid_ff[q_ff];
   assign stat.rsp_busy = rsp_valid_ff;

   // Link write: on push append to the old tail, on pop chain the freed
   // entry in front of the free list. Both store the current free head.
   assign link_we = (cmd.do_push && qvalid_ff[q_ff]) || cmd.do_pop;
   assign link_wa = cmd.do_pop ? head_rd[AW-1:0] : tail_rd[AW-1:0];
   assign link_ra = cmd.issue_pop ? head_rd[AW-1:0] : free_head_ff[AW-1:0];
   assign head_wd = cmd.do_pop ? link_rd : free_head_ff;

   mqsb_ram #(.WIDTH(PTR_W), .DEPTH(QUEUES)) u_head_ram (
      .clock   (clock),
      .wr_en   ((cmd.do_push && !qvalid_ff[q_ff]) || cmd.do_pop),
      .wr_addr (q_ff),
      .wr_data (head_wd),
      .rd_en   (cmd.load),
      .rd_addr (q_req),
      .rd_data (head_rd)
   );

   mqsb_ram #(.WIDTH(PTR_W), .DEPTH(QUEUES)) u_tail_ram (
      .clock   (clock),
      .wr_en   (cmd.do_push),
      .wr_addr (q_ff),
      .wr_data (free_head_ff),
      .rd_en   (cmd.load),
      .rd_addr (q_req),
      .rd_data (tail_rd)
   );

   mqsb_ram #(.WIDTH(PTR_W), .DEPTH(ENTRIES)) u_link_ram (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (link_wa),
      .wr_data (free_head_ff),
      .rd_en   (cmd.load || cmd.issue_pop),
      .rd_addr (link_ra),
      .rd_data (link_rd)
   );

   mqsb_ram #(.WIDTH(DATA_WIDTH), .DEPTH(ENTRIES)) u_value_ram (
      .clock   (clock),
      .wr_en   (cmd.do_push),
      .wr_addr (free_head_ff[AW-1:0]),
      .wr_data (val_ff),
      .rd_en   (cmd.issue_pop),
      .rd_addr (head_rd[AW-1:0]),
      .rd_data (value_rd)
   );

   always_comb begin
      free_head_in  = free_head_ff;
      fill_in       = fill_ff;
      qvalid_in     = qvalid_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      if (cmd.do_push) begin
         free_head_in    = next_free;
         qvalid_in[q_ff] = 1'b1;
         if (fresh) begin
            fill_in = fill_ff + PTR_W'(1);
         end
         rsp_valid_in  = 1'b1;
         rsp_value_in  = '0;
         rsp_status_in = ST_OK;
      end
      if (cmd.do_pop) begin
         free_head_in    = head_rd;
         // the queue drains when its head is also its tail
         qvalid_in[q_ff] = (head_rd != tail_rd);
         rsp_valid_in    = 1'b1;
         rsp_value_in    = rd_ext[VALUE_W-1:0];
         rsp_status_in   = ST_OK;
      end
      if (cmd.do_error) begin
         rsp_valid_in  = 1'b1;
         rsp_value_in  = '0;
         rsp_status_in = stat.is_pop ? ST_UNDERFLOW : ST_OVERFLOW;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_head_ff <= '0;
         fill_ff      <= '0;
         qvalid_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         free_head_ff <= free_head_in;
         fill_ff      <= fill_in;
         qvalid_ff    <= qvalid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= req_opcode;
         q_ff   <= q_req;
         val_ff <= wr_ext[DATA_WIDTH-1:0];
      end
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_value_out = rsp_value_ff;
   assign rsp_status    = rsp_status_ff;

endmodule

FILE: sim/multi_queue_shared_buffer_checker.sv
// Watches both channels of the shared-buffer queues, predicts each response and compares it.
module multi_queue_shared_buffer_checker #(
   parameter int ENTRIES = mqsb_pkg::DEF_ENTRIES,
   parameter int QUEUES  = mqsb_pkg::DEF_QUEUES
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic [mqsb_pkg::OPCODE_W-1:0]       req_opcode,
   input  logic [mqsb_pkg::QIDX_W-1:0]         req_queue_index,
   input  logic signed [mqsb_pkg::VALUE_W-1:0] req_value_in,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic signed [mqsb_pkg::VALUE_W-1:0] rsp_value_out,
   input  logic [mqsb_pkg::STATUS_W-1:0]       rsp_status,
   output int                                  errors,
   output int                                  outstanding
);
   import mqsb_pkg::*;

   localparam int PTR_W = $clog2(ENTRIES + 1);
   localparam logic [PTR_W-1:0] NIL = PTR_W'(ENTRIES);

   typedef logic [PTR_W-1:0] ptr_type;

   typedef struct packed {
      logic [VALUE_W-1:0]  value;
      logic [STATUS_W-1:0] status;
   } queue_result_type;

   ptr_type            q_head [QUEUES];
   ptr_type            q_tail [QUEUES];
   ptr_type            next_entry [ENTRIES];
   logic [VALUE_W-1:0] entry_value [ENTRIES];
   ptr_type            free_head;

   queue_result_type   awaited_results [$];

   // Advance the queue state by one operation and return its response.
   function automatic queue_result_type apply_queue_op(logic [OPCODE_W-1:0] op,
                                                       logic [QIDX_W-1:0] qi,
                                                       logic [VALUE_W-1:0] v);
      queue_result_type r;
      int unsigned      q;
      ptr_type          slot;
      r.value  = '0;
      r.status = ST_OK;
      q = int'(qi) % QUEUES;
      if (op == OP_PUSH) begin
         if (free_head >= ENTRIES) begin
            r.status = ST_OVERFLOW;
         end else begin
            slot      = free_head;
            free_head = next_entry[slot];
            // a stale tail on an empty queue is ignored
            if (q_head[q] >= ENTRIES) begin
               q_head[q] = slot;
            end else if (q_tail[q] < ENTRIES) begin
               next_entry[q_tail[q]] = slot;
            end
            next_entry[slot]  = NIL;
            q_tail[q]         = slot;
            entry_value[slot] = v;
         end
      end else begin
         if (q_head[q] >= ENTRIES) begin
            r.status = ST_UNDERFLOW;
         end else begin
            slot             = q_head[q];
            q_head[q]        = next_entry[slot];
            next_entry[slot] = free_head;
            free_head        = slot;
            r.value          = entry_value[slot];
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin
      queue_result_type want;
      if (reset) begin
         for (int i = 0; i < QUEUES; i++) begin
            q_head[i] = NIL;
            q_tail[i] = NIL;
         end
         for (int i = 0; i < ENTRIES; i++) begin
            next_entry[i]  = ptr_type'(i + 1);
            entry_value[i] = '0;
         end
         next_entry[ENTRIES-1] = NIL;
         free_head = '0;
         awaited_results.delete();
         errors = 0;
      end else begin
         if (req_valid && req_ready) begin
            awaited_results.push_back(apply_queue_op(req_opcode, req_queue_index,
                                                     req_value_in));
         end
         if (rsp_valid && rsp_ready) begin
            if (awaited_results.size() == 0) begin
               $display("%0t: unexpected response value_out %h status %0d",
                        $time, rsp_value_out, rsp_status);
               errors++;
            end else begin
               want = awaited_results.pop_front();
               if (rsp_value_out !== want.value) begin
                  $display("%0t: value_out expected %h actual %h",
                           $time, want.value, rsp_value_out);
                  errors++;
               end
               if (rsp_status !== want.status) begin
                  $display("%0t: status expected %0d actual %0d",
                           $time, want.status, rsp_status);
                  errors++;
               end
            end
         end
      end
      outstanding = awaited_results.size();
   end

endmodule

FILE: sim/multi_queue_shared_buffer_test.sv
// Testbench top for the multi-queue shared buffer: clock, reset, stimulus and verdict.
module multi_queue_shared_buffer_test;
   import mqsb_pkg::*;

   localparam int LONG_HOLD   = 80;       // cycles the receiver refuses responses
   localparam int RUN_LIMIT   = 1000000;  // time units before the run is abandoned
   localparam int BLOCKS      = 50;
   localparam int BLOCK_ITEMS = 40;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid;
   logic                      req_ready;
   logic [OPCODE_W-1:0]       req_opcode;
   logic [QIDX_W-1:0]         req_queue_index;
   logic signed [VALUE_W-1:0] req_value_in;
   logic                      rsp_valid;
   logic                      rsp_ready;
   logic signed [VALUE_W-1:0] rsp_value_out;
   logic [STATUS_W-1:0]       rsp_status;

   int   errors;
   int   outstanding;

   // Set by the stimulus to ask the receiver for one long hold-off.
   bit   rsp_hold_req = 1'b0;
   // Set for the closing stretch of the run: no idling on either side.
   bit   tail_phase   = 1'b0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   multi_queue_shared_buffer dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_opcode      (req_opcode),
      .req_queue_index (req_queue_index),
      .req_value_in    (req_value_in),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_value_out   (rsp_value_out),
      .rsp_status      (rsp_status)
   );

   multi_queue_shared_buffer_checker checker_i (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_opcode      (req_opcode),
      .req_queue_index (req_queue_index),
      .req_value_in    (req_value_in),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_value_out   (rsp_value_out),
      .rsp_status      (rsp_status),
      .errors          (errors),
      .outstanding     (outstanding)
   );

   // Offer one item at the falling edge and hold it until the block takes it.
   // Insert a short random gap first unless the run is in its closing stretch.
   task automatic send_item(input logic [OPCODE_W-1:0] op,
                            input logic [QIDX_W-1:0]   q,
                            input logic [VALUE_W-1:0]  v);
      if (!tail_phase && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_opcode      <= op;
      req_queue_index <= q;
      req_value_in    <= v;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // Receiver pacing: mostly ready, short random stalls, and one long
   // hold-off on request. Each stretch is counted here, in falling edges.
   initial begin : rsp_pacing
      int n;
      bit hold_done;
      hold_done = 1'b0;
      rsp_ready = 1'b0;
      while (reset) @(negedge clock);
      forever begin
         if (rsp_hold_req && !hold_done) begin
            hold_done = 1'b1;
            rsp_ready <= 1'b0;
            n = LONG_HOLD;
         end else if (!tail_phase && $urandom_range(0, 4) == 0) begin
            rsp_ready <= 1'b0;
            n = $urandom_range(1, 3);
         end else begin
            rsp_ready <= 1'b1;
            n = $urandom_range(1, 8);
         end
         repeat (n) @(negedge clock);
      end
   end

   // Abandon a run that hangs.
   initial begin : watchdog
      #(RUN_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin : stimulus
      logic [VALUE_W-1:0]  extremes [4];
      logic [OPCODE_W-1:0] op;
      logic [QIDX_W-1:0]   q;
      logic [QIDX_W-1:0]   focus_q;
      bit                  focused;
      int                  push_pct;

      // Drive every input to a known value before the first edge.
      req_valid       = 1'b0;
      req_opcode      = OP_PUSH;
      req_queue_index = '0;
      req_value_in    = '0;

      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // Directed part.
      extremes[0] = 32'h8000_0000;
      extremes[1] = 32'h7FFF_FFFF;
      extremes[2] = 32'hFFFF_FFFF;
      extremes[3] = 32'h0000_0000;

      // Pop from an empty queue right after reset: underflow.
      send_item(OP_POP, 2'd0, 32'h1234_5678);
      // One push per queue with extreme values.
      for (int i = 0; i < 4; i++) send_item(OP_PUSH, QIDX_W'(i), extremes[i]);
      // Empty queue 3, hit underflow on it, push again over its stale tail, then pop it.
      send_item(OP_POP, 2'd3, 32'hFFFF_FFFF);
      send_item(OP_POP, 2'd3, 32'h0);
      send_item(OP_PUSH, 2'd3, 32'h5555_5555);
      send_item(OP_POP, 2'd3, 32'h0);
      // Fill the rest of the buffer, then push once more: overflow.
      for (int i = 0; i < 13; i++) begin
         send_item(OP_PUSH, QIDX_W'(i), (i % 2 == 0) ? 32'hAAAA_AAAA : $urandom);
      end
      send_item(OP_PUSH, 2'd1, 32'hDEAD_BEEF);
      // Drain the heads of the first three queues.
      for (int i = 0; i < 3; i++) send_item(OP_POP, QIDX_W'(i), 32'h0);

      // Random part: blocks with a push bias so that the buffer swings
      // between empty and full, some blocks aimed at a single queue.
      for (int blk = 0; blk < BLOCKS; blk++) begin
         case ($urandom_range(0, 3))
            0: push_pct = 20;
            1: push_pct = 50;
            2: push_pct = 75;
            default: push_pct = 95;
         endcase
         focused = ($urandom_range(0, 2) == 0);
         focus_q = QIDX_W'($urandom_range(0, 3));

         // Stall the receiver for a long stretch while items keep coming.
         if (blk == 15) rsp_hold_req = 1'b1;
         // Pause the sender until every response is back.
         if (blk == 30) begin
            req_valid <= 1'b0;
            wait (outstanding == 0);
            @(negedge clock);
         end
         // Closing stretch: back-to-back traffic.
         if (blk == BLOCKS - 5) tail_phase = 1'b1;

         for (int i = 0; i < BLOCK_ITEMS; i++) begin
            op = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP;
            q  = focused ? focus_q : QIDX_W'($urandom_range(0, 3));
            send_item(op, q, $urandom);
         end
      end

      // Drop valid and let every response drain, then idle before the verdict.
      req_valid <= 1'b0;
      wait (outstanding == 0);
      repeat (10) @(negedge clock);
      if (errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/mqsb_pkg.sv
rtl/mqsb_ram.sv
rtl/mqsb_ctrl.sv
rtl/mqsb_dpath.sv
rtl/multi_queue_shared_buffer.sv
sim/multi_queue_shared_buffer_checker.sv
sim/multi_queue_shared_buffer_test.sv
